@@ hdl/ejc_pkg.sv @@
`timescale 1ns / 1ps
package ejc_pkg;

  // Field widths fixed by the word format
  localparam int ACT_W       = 3;
  localparam int POS_W       = 7;
  localparam int STORE_DEPTH = 81;
  localparam int ADDR_W      = 7;
  localparam int COMP_LAST   = 8;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ELASTIC     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ELASTIC_ROT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MOMENT      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_MOMENT_ROT  = 3'd4;

  // Accumulator codes: three partial sums and the result sum
  localparam logic [1:0] ACC_P0  = 2'd0;
  localparam logic [1:0] ACC_P1  = 2'd1;
  localparam logic [1:0] ACC_P2  = 2'd2;
  localparam logic [1:0] ACC_SUM = 2'd3;

  // Multiplier operand sources
  typedef enum logic [1:0] {A_RAM, A_ACC, A_TEST} a_sel_t;
  typedef enum logic [2:0] {B_SGRAD, B_TGRAD, B_PHI, B_TEST, B_ACC0} b_sel_t;

  // One issue slot of the shared multiply-accumulate
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              pass;
    logic              sub;
    logic [ADDR_W-1:0] addr;
    a_sel_t            a_sel;
    logic [1:0]        a_idx;
    b_sel_t            b_sel;
    logic [1:0]        b_idx;
    logic [1:0]        dst;
  } term_t;

  typedef struct packed {
    logic take;
    logic load;
  } ctl_t;

  typedef struct packed {
    logic out_busy;
    logic pipe_busy;
  } stat_t;

endpackage

@@ hdl/ejc_ram.sv @@
`timescale 1ns / 1ps
module ejc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/ejc_ctrl.sv @@
`timescale 1ns / 1ps
module ejc_ctrl
  import ejc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] in_action,
  input  logic [POS_W-1:0] in_position,
  input  stat_t            stat,
  output ctl_t             ctl,
  output term_t            term
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

  state_t           state_r, state_nxt;
  logic [ACT_W-1:0] act_r, act_nxt;
  logic [1:0]       i_r, i_nxt, k_r, k_nxt;
  logic [3:0]       step_r, step_nxt;
  logic             drain_r, drain_nxt;
  term_t            term_r, term_nxt, dec;
  logic [1:0]       ia, ib, kc, kd;
  logic [3:0]       jl;
  logic [3:0]       ik;
  logic             fire;

  // (x + 1) mod 3
  function automatic logic [1:0] nxt3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  // {v / 3, v mod 3} for v up to 8
  function automatic logic [3:0] split3(input logic [3:0] v);
    logic [3:0] r;
    unique case (v)
      4'd0:    r = {2'd0, 2'd0};
      4'd1:    r = {2'd0, 2'd1};
      4'd2:    r = {2'd0, 2'd2};
      4'd3:    r = {2'd1, 2'd0};
      4'd4:    r = {2'd1, 2'd1};
      4'd5:    r = {2'd1, 2'd2};
      4'd6:    r = {2'd2, 2'd0};
      4'd7:    r = {2'd2, 2'd1};
      4'd8:    r = {2'd2, 2'd2};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Flat store index of C[a][b][c][d]
  function automatic logic [ADDR_W-1:0] ent_addr(input logic [1:0] a, input logic [1:0] b,
                                                 input logic [1:0] c, input logic [1:0] d);
    return ADDR_W'(a) * ADDR_W'(27) + ADDR_W'(b) * ADDR_W'(9)
         + ADDR_W'(c) * ADDR_W'(3) + ADDR_W'(d);
  endfunction

  // Levi-Civita partners of row i and column k
  assign ia = nxt3(i_r);
  assign ib = nxt3(ia);
  assign kc = nxt3(k_r);
  assign kd = nxt3(kc);
  assign jl = split3(step_r);
  assign ik = split3(in_position[3:0]);

  // Decode the issue slot for the current step
  always_comb begin
    dec = '0;
    unique case (act_r)
      ACT_ELASTIC: begin
        dec.valid = 1'b1;
        if (step_r < 4'd9) begin
          dec.addr  = ent_addr(i_r, jl[3:2], k_r, jl[1:0]);
          dec.a_sel = A_RAM;
          dec.b_sel = B_SGRAD;
          dec.b_idx = jl[1:0];
          dec.dst   = jl[3:2];
        end else begin
          dec.a_sel = A_ACC;
          dec.a_idx = 2'(step_r - 4'd9);
          dec.b_sel = B_TGRAD;
          dec.b_idx = 2'(step_r - 4'd9);
          dec.dst   = ACC_SUM;
          dec.last  = (step_r == 4'd11);
        end
      end
      ACT_ELASTIC_ROT: begin
        if (step_r < 4'd6) begin
          dec.valid = 1'b1;
          dec.sub   = step_r[0];
          dec.addr  = step_r[0] ? ent_addr(i_r, step_r[2:1], kd, kc)
                                : ent_addr(i_r, step_r[2:1], kc, kd);
          dec.a_sel = A_RAM;
          dec.b_sel = B_TGRAD;
          dec.b_idx = step_r[2:1];
          dec.dst   = ACC_P0;
        end else if (step_r == 4'd7) begin
          dec.valid = 1'b1;
          dec.a_sel = A_ACC;
          dec.a_idx = ACC_P0;
          dec.b_sel = B_PHI;
          dec.dst   = ACC_SUM;
          dec.last  = 1'b1;
        end
      end
      ACT_MOMENT: begin
        if (step_r < 4'd6) begin
          dec.valid = 1'b1;
          dec.sub   = step_r[0];
          dec.addr  = step_r[0] ? ent_addr(ib, ia, k_r, step_r[2:1])
                                : ent_addr(ia, ib, k_r, step_r[2:1]);
          dec.a_sel = A_RAM;
          dec.b_sel = B_SGRAD;
          dec.b_idx = step_r[2:1];
          dec.dst   = ACC_P0;
        end else if (step_r == 4'd7) begin
          dec.valid = 1'b1;
          dec.a_sel = A_ACC;
          dec.a_idx = ACC_P0;
          dec.b_sel = B_TEST;
          dec.dst   = ACC_SUM;
          dec.last  = 1'b1;
        end
      end
      ACT_MOMENT_ROT: begin
        if (step_r == 4'd0) begin
          dec.valid = 1'b1;
          dec.a_sel = A_TEST;
          dec.b_sel = B_PHI;
          dec.dst   = ACC_P0;
        end else if (step_r < 4'd5) begin
          // raw entries, signs from both Levi-Civita symbols
          dec.valid = 1'b1;
          dec.pass  = 1'b1;
          dec.a_sel = A_RAM;
          dec.dst   = ACC_P1;
          unique case (step_r[1:0])
            2'd1: dec.addr = ent_addr(ia, ib, kc, kd);
            2'd2: begin
              dec.addr = ent_addr(ia, ib, kd, kc);
              dec.sub  = 1'b1;
            end
            2'd3: begin
              dec.addr = ent_addr(ib, ia, kc, kd);
              dec.sub  = 1'b1;
            end
            default: dec.addr = ent_addr(ib, ia, kd, kc);
          endcase
        end else if (step_r == 4'd6) begin
          dec.valid = 1'b1;
          dec.a_sel = A_ACC;
          dec.a_idx = ACC_P1;
          dec.b_sel = B_ACC0;
          dec.dst   = ACC_SUM;
          dec.last  = 1'b1;
        end
      end
      default: dec = '0;
    endcase
  end

  // Accept words, walk the steps, drain the pipe
  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    step_nxt  = step_r;
    drain_nxt = drain_r;
    term_nxt  = '0;
    ctl       = '0;
    in_ready  = (state_r == S_IDLE);
    fire      = in_valid && in_ready;
    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          unique case (in_action) inside
            ACT_LOAD: ctl.load = (in_position < POS_W'(STORE_DEPTH));
            ACT_ELASTIC, ACT_ELASTIC_ROT, ACT_MOMENT, ACT_MOMENT_ROT: begin
              if (in_position <= POS_W'(COMP_LAST)) begin
                ctl.take  = 1'b1;
                act_nxt   = in_action;
                i_nxt     = ik[3:2];
                k_nxt     = ik[1:0];
                step_nxt  = 4'd0;
                state_nxt = S_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        // hold the final slot until the output register is free
        if (!(dec.last && stat.out_busy)) begin
          term_nxt = dec;
          step_nxt = step_r + 4'd1;
          if (dec.last) begin
            drain_nxt = 1'b0;
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= '0;
      act_r   <= '0;
      i_r     <= '0;
      k_r     <= '0;
      step_r  <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      act_r   <= act_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      step_r  <= step_nxt;
      drain_r <= drain_nxt;
    end
  end

  assign term = term_r;

endmodule

@@ hdl/ejc_dp.sv @@
`timescale 1ns / 1ps
module ejc_dp
  import ejc_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [POS_W-1:0]       in_position,
  input  logic [VALUE_WIDTH-1:0] in_entry_value,
  input  logic [VALUE_WIDTH-1:0] in_test_grad_x,
  input  logic [VALUE_WIDTH-1:0] in_test_grad_y,
  input  logic [VALUE_WIDTH-1:0] in_test_grad_z,
  input  logic [VALUE_WIDTH-1:0] in_shape_grad_x,
  input  logic [VALUE_WIDTH-1:0] in_shape_grad_y,
  input  logic [VALUE_WIDTH-1:0] in_shape_grad_z,
  input  logic [VALUE_WIDTH-1:0] in_test_scalar,
  input  logic [VALUE_WIDTH-1:0] in_shape_scalar,
  input  ctl_t                   ctl,
  input  term_t                  term,
  output stat_t                  stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_jacobian_value,
  output logic                   out_overflow
);

  localparam int VW    = VALUE_WIDTH;
  localparam int GUARD = 3;
  localparam int AW    = VW + GUARD;
  localparam int PW    = AW + VW;
  localparam int SW    = AW + 1;
  localparam logic signed [PW-1:0] RND  = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic [VW-1:0]        MAXV = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0]        MINV = {1'b1, {(VW-1){1'b0}}};

  logic signed [VW-1:0] tg_r [3];
  logic signed [VW-1:0] sg_r [3];
  logic signed [VW-1:0] tst_r, phi_r;
  logic signed [AW-1:0] acc0_r, acc1_r, acc2_r, sum_r;
  logic                 ovf_r;
  term_t                s1_r, s2_r;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [VW-1:0]        rdata;
  logic signed [AW-1:0] a_op;
  logic signed [VW-1:0] b_op;
  logic signed [PW-1:0] adj, q;
  logic [PW-VW:0]       q_hi;
  logic                 prod_sat;
  logic [VW-1:0]        prod_val;
  logic signed [AW-1:0] term_val;
  logic                 term_sat;
  logic signed [AW-1:0] acc_sel, acc_upd;
  logic signed [SW-1:0] fin_sum;
  logic [SW-VW:0]       fin_hi;
  logic                 fin_sat;
  logic [VW-1:0]        fin_val;
  logic                 out_valid_r;
  logic [VW-1:0]        out_val_r;
  logic                 out_ovf_r;

  // Stiffness store: write on load, read address from the issue slot
  ejc_ram #(
    .WIDTH (VW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctl.load),
    .waddr (in_position),
    .wdata (in_entry_value),
    .raddr (term.addr),
    .rdata (rdata)
  );

  // Stage 1: pick operands and multiply
  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (s1_r.a_sel)
      A_RAM:  a_op = {{GUARD{rdata[VW-1]}}, rdata};
      A_ACC: begin
        case (s1_r.a_idx)
          ACC_P0:  a_op = acc0_r;
          ACC_P1:  a_op = acc1_r;
          ACC_P2:  a_op = acc2_r;
          default: a_op = sum_r;
        endcase
      end
      A_TEST: a_op = {{GUARD{tst_r[VW-1]}}, tst_r};
      default: a_op = '0;
    endcase
    unique case (s1_r.b_sel)
      B_SGRAD: b_op = sg_r[s1_r.b_idx];
      B_TGRAD: b_op = tg_r[s1_r.b_idx];
      B_PHI:   b_op = phi_r;
      B_TEST:  b_op = tst_r;
      B_ACC0:  b_op = acc0_r[VW-1:0];
      default: b_op = '0;
    endcase
    if (s1_r.pass) begin
      prod_nxt = PW'(a_op);
    end else begin
      prod_nxt = a_op * b_op;
    end
  end

  // Stage 2: truncate toward zero, saturate, accumulate
  always_comb begin
    adj      = prod_r + (prod_r[PW-1] ? RND : '0);
    q        = adj >>> FRAC_BITS;
    q_hi     = q[PW-1:VW-1];
    prod_sat = !((&q_hi) || !(|q_hi));
    prod_val = prod_sat ? (q[PW-1] ? MINV : MAXV) : q[VW-1:0];
    if (s2_r.pass) begin
      term_val = prod_r[AW-1:0];
      term_sat = 1'b0;
    end else begin
      term_val = {{GUARD{prod_val[VW-1]}}, prod_val};
      term_sat = prod_sat;
    end
    case (s2_r.dst)
      ACC_P0:  acc_sel = acc0_r;
      ACC_P1:  acc_sel = acc1_r;
      ACC_P2:  acc_sel = acc2_r;
      default: acc_sel = sum_r;
    endcase
    acc_upd = s2_r.sub ? acc_sel - term_val : acc_sel + term_val;
    fin_sum = SW'(sum_r) + SW'(term_val);
    fin_hi  = fin_sum[SW-1:VW-1];
    fin_sat = !((&fin_hi) || !(|fin_hi));
    fin_val = fin_sat ? (fin_sum[SW-1] ? MINV : MAXV) : fin_sum[VW-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      s1_r <= term;
      s2_r <= s1_r;
      if (ctl.take) begin
        ovf_r <= 1'b0;
      end else if (s2_r.valid) begin
        ovf_r <= ovf_r | term_sat;
      end
      if (s2_r.valid && s2_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl.take) begin
      tg_r[0] <= in_test_grad_x;
      tg_r[1] <= in_test_grad_y;
      tg_r[2] <= in_test_grad_z;
      sg_r[0] <= in_shape_grad_x;
      sg_r[1] <= in_shape_grad_y;
      sg_r[2] <= in_shape_grad_z;
      tst_r   <= in_test_scalar;
      phi_r   <= in_shape_scalar;
      acc0_r  <= '0;
      acc1_r  <= '0;
      acc2_r  <= '0;
      sum_r   <= '0;
    end else if (s2_r.valid && !s2_r.last) begin
      case (s2_r.dst)
        ACC_P0:  acc0_r <= acc_upd;
        ACC_P1:  acc1_r <= acc_upd;
        ACC_P2:  acc2_r <= acc_upd;
        default: sum_r  <= acc_upd;
      endcase
    end
    if (s2_r.valid && s2_r.last) begin
      out_val_r <= fin_val;
      out_ovf_r <= ovf_r | term_sat | fin_sat;
    end
  end

  assign stat.out_busy     = out_valid_r;
  assign stat.pipe_busy    = s1_r.valid || s2_r.valid;
  assign out_valid          = out_valid_r;
  assign out_jacobian_value = out_val_r;
  assign out_overflow       = out_ovf_r;

endmodule

@@ hdl/elasticity_jacobian_contraction.sv @@
`timescale 1ns / 1ps
// Channel  Handshake              Word contents
// in_      in_valid / in_ready    action, position, entry_value, gradients, scalars
// out_     out_valid / out_ready  jacobian_value, overflow
//
// A load word, or a word that is dropped, leaves the input ready for the next word.
// A compute word issues its slots one after another to the one shared
// multiply-accumulate; the final slot is carried through issue and multiply, and it
// accumulates in the first cycle in which the next word can be taken.
// Reset is synchronous, active low; the stiffness store keeps its contents.
// A waiting result does not block new words; only the final slot of the next compute
// holds until the output register has been taken.
module elasticity_jacobian_contraction
  import ejc_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACT_W-1:0]       in_action,
  input  logic [POS_W-1:0]       in_position,
  input  logic [VALUE_WIDTH-1:0] in_entry_value,
  input  logic [VALUE_WIDTH-1:0] in_test_grad_x,
  input  logic [VALUE_WIDTH-1:0] in_test_grad_y,
  input  logic [VALUE_WIDTH-1:0] in_test_grad_z,
  input  logic [VALUE_WIDTH-1:0] in_shape_grad_x,
  input  logic [VALUE_WIDTH-1:0] in_shape_grad_y,
  input  logic [VALUE_WIDTH-1:0] in_shape_grad_z,
  input  logic [VALUE_WIDTH-1:0] in_test_scalar,
  input  logic [VALUE_WIDTH-1:0] in_shape_scalar,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_jacobian_value,
  output logic                   out_overflow
);

  ctl_t  ctl;
  term_t term;
  stat_t stat;

  ejc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_position (in_position),
    .stat        (stat),
    .ctl         (ctl),
    .term        (term)
  );

  ejc_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_position        (in_position),
    .in_entry_value     (in_entry_value),
    .in_test_grad_x     (in_test_grad_x),
    .in_test_grad_y     (in_test_grad_y),
    .in_test_grad_z     (in_test_grad_z),
    .in_shape_grad_x    (in_shape_grad_x),
    .in_shape_grad_y    (in_shape_grad_y),
    .in_shape_grad_z    (in_shape_grad_z),
    .in_test_scalar     (in_test_scalar),
    .in_shape_scalar    (in_shape_scalar),
    .ctl                (ctl),
    .term               (term),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_jacobian_value (out_jacobian_value),
    .out_overflow       (out_overflow)
  );

  // Final slot only goes out when the result register is free
  a_last_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    term.valid && term.last |-> !stat.out_busy)
    else $error("final slot issued while a result is still waiting");

  // A new word only enters with no slot in issue, and the pipe is empty behind it
  a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !term.valid ##1 !stat.pipe_busy)
    else $error("word accepted while the pipe still holds work");

  // A result rises only behind a final slot, carried through both stages into the output register
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(term.valid && term.last, 3))
    else $error("result without a matching final slot");

  // A load word does not stall the input: it is ready again in the next cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_LOAD |=> in_ready)
    else $error("load word stalled the input");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb
  import ejc_pkg::*;
();

  localparam int FRAC_BITS  = 16;
  localparam int VALUE_W    = 32;
  localparam int POS_TOP    = 2**POS_W - 1;
  localparam int RANDOM_WORDS = 1800;
  localparam int PAUSE_AT   = 1300;
  localparam int HOLD_AFTER = 900;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN      = 40;
  localparam int IDLE_LIMIT = 5000;

  // Action codes the block leaves unused
  localparam logic [ACT_W-1:0] ACT_SPARE5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;

  // Q16.16 landmarks
  localparam logic [31:0] QMAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] QMIN  = 32'h8000_0000;
  localparam logic [31:0] QONE  = 32'h0001_0000;
  localparam logic [31:0] QZERO = 32'h0000_0000;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] position;
    logic [31:0]      entry;
    logic [31:0]      tx, ty, tz;
    logic [31:0]      sx, sy, sz;
    logic [31:0]      test;
    logic [31:0]      phi;
  } word_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } jac_t;

  typedef struct packed {
    word_t w;
    logic  known;
    jac_t  res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_overflow;
  logic [ACT_W-1:0] in_action;
  logic [POS_W-1:0] in_position;
  logic [VALUE_W-1:0] in_entry_value, in_test_scalar, in_shape_scalar;
  logic [VALUE_W-1:0] in_test_grad_x, in_test_grad_y, in_test_grad_z;
  logic [VALUE_W-1:0] in_shape_grad_x, in_shape_grad_y, in_shape_grad_z;
  logic [VALUE_W-1:0] out_jacobian_value;

  longint tensor_c [STORE_DEPTH];
  bit     sat_hit;
  jac_t   jac_due [$];
  jac_t   head;
  int     errors, results_seen, saturated, words_taken, loads, dropped, quiet;
  int     per_action [8];
  int     burst_left;

  always #5 clk = ~clk;

  elasticity_jacobian_contraction #(
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_WIDTH(VALUE_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_position       (in_position),
    .in_entry_value    (in_entry_value),
    .in_test_grad_x    (in_test_grad_x),
    .in_test_grad_y    (in_test_grad_y),
    .in_test_grad_z    (in_test_grad_z),
    .in_shape_grad_x   (in_shape_grad_x),
    .in_shape_grad_y   (in_shape_grad_y),
    .in_shape_grad_z   (in_shape_grad_z),
    .in_test_scalar    (in_test_scalar),
    .in_shape_scalar   (in_shape_scalar),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_jacobian_value(out_jacobian_value),
    .out_overflow      (out_overflow)
  );

  // Directed words; run after every tensor entry has been loaded with QMAX.
  // With a fully symmetric tensor the Levi-Civita terms cancel to zero.
  localparam int PLAN_LEN = 23;
  row_t plan [PLAN_LEN] = '{
    '{'{ACT_ELASTIC, 7'd0, QZERO, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QZERO, QZERO},
      1'b1, '{QMAX, 1'b1}},
    '{'{ACT_ELASTIC, 7'd8, QZERO, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QZERO, QZERO},
      1'b1, '{QMIN, 1'b1}},
    '{'{ACT_ELASTIC, 7'd4, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO},
      1'b1, '{QZERO, 1'b0}},
    '{'{ACT_ELASTIC_ROT, 7'd4, QZERO, QONE, QONE, QONE, QMIN, QMIN, QMIN, QMAX, QONE},
      1'b1, '{QZERO, 1'b0}},
    '{'{ACT_MOMENT, 7'd2, QZERO, QMAX, QMAX, QMAX, QONE, QONE, QONE, QONE, QMIN},
      1'b1, '{QZERO, 1'b0}},
    '{'{ACT_MOMENT_ROT, 7'd8, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QMAX, QMAX},
      1'b1, '{QZERO, 1'b1}},
    '{'{ACT_MOMENT_ROT, 7'd0, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN},
      1'b1, '{QZERO, 1'b1}},
    // break the symmetry with extreme and small entries
    '{'{ACT_LOAD, 7'd80, QMIN, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO},
      1'b0, '{QZERO, 1'b0}},
    '{'{ACT_LOAD, 7'd0, QZERO, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX},
      1'b0, '{QZERO, 1'b0}},
    '{'{ACT_LOAD, 7'd81, 32'h1234_5678, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
      QZERO}, 1'b0, '{QZERO, 1'b0}},
    '{'{ACT_LOAD, 7'(POS_TOP), QMIN, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO},
      1'b0, '{QZERO, 1'b0}},
    '{'{ACT_LOAD, 7'd5, QONE, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO},
      1'b0, '{QZERO, 1'b0}},
    '{'{ACT_LOAD, 7'd41, 32'hFFFF_0000, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
      QZERO}, 1'b0, '{QZERO, 1'b0}},
    '{'{ACT_LOAD, 7'd15, 32'h0002_8000, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
      QZERO}, 1'b0, '{QZERO, 1'b0}},
    // words the block must drop
    '{'{ACT_ELASTIC, 7'd9, QZERO, QONE, QONE, QONE, QONE, QONE, QONE, QONE, QONE},
      1'b0, '{QZERO, 1'b0}},
    '{'{ACT_MOMENT, 7'(POS_TOP), QZERO, QONE, QONE, QONE, QONE, QONE, QONE, QONE, QONE},
      1'b0, '{QZERO, 1'b0}},
    '{'{ACT_SPARE5, 7'd0, QONE, QONE, QONE, QONE, QONE, QONE, QONE, QONE, QONE},
      1'b0, '{QZERO, 1'b0}},
    '{'{ACT_SPARE6, 7'd3, QONE, QONE, QONE, QONE, QONE, QONE, QONE, QONE, QONE},
      1'b0, '{QZERO, 1'b0}},
    '{'{ACT_SPARE7, 7'd8, QONE, QONE, QONE, QONE, QONE, QONE, QONE, QONE, QONE},
      1'b0, '{QZERO, 1'b0}},
    // mixed values, checked by the predictor
    '{'{ACT_ELASTIC, 7'd0, QZERO, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000, QONE,
      32'hFFFF_8000, 32'h0003_0000, QZERO, QZERO}, 1'b0, '{QZERO, 1'b0}},
    '{'{ACT_ELASTIC_ROT, 7'd0, QZERO, QONE, 32'h0000_2000, QMIN, QZERO, QZERO, QZERO,
      QZERO, 32'hFFFF_C000}, 1'b0, '{QZERO, 1'b0}},
    '{'{ACT_MOMENT, 7'd8, QZERO, QZERO, QZERO, QZERO, 32'h0000_0100, QMAX, 32'hFFFF_FFFF,
      32'h0000_8000, QZERO}, 1'b0, '{QZERO, 1'b0}},
    '{'{ACT_MOMENT_ROT, 7'd7, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO, QZERO,
      32'h0003_0000, 32'hFFFE_8000}, 1'b0, '{QZERO, 1'b0}}
  };

  // Saturate to a signed 32-bit value, noting any clip
  function automatic longint clip_q(logic signed [127:0] v);
    logic [127:0] m, lim;
    logic neg;
    neg = v < 0;
    m   = neg ? -v : v;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (m > lim) begin
      sat_hit = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  // Exact product, truncated toward zero to Q16.16, then saturated
  function automatic longint q_mul(longint a, longint b);
    logic signed [127:0] wa, wb, prod;
    logic [127:0] m;
    wa   = a;
    wb   = b;
    prod = wa * wb;
    m    = prod < 0 ? -prod : prod;
    m    = m >> FRAC_BITS;
    return clip_q(prod < 0 ? -$signed(m) : $signed(m));
  endfunction

  function automatic longint c_at(int p, int q, int u, int v);
    return tensor_c[p * 27 + q * 9 + u * 3 + v];
  endfunction

  // Update the tensor copy or work out the Jacobian entry for one word
  function automatic logic predict_jacobian(input word_t w, output jac_t r);
    longint t [3];
    longint g [3];
    longint test, phi, s, inner, sum;
    int i, k, a, b, c, d;
    r = '0;
    if (w.action == ACT_LOAD) begin
      if (w.position < STORE_DEPTH) tensor_c[w.position] = longint'($signed(w.entry));
      return 1'b0;
    end
    if (w.action > ACT_MOMENT_ROT || w.position > COMP_LAST) return 1'b0;
    t[0] = longint'($signed(w.tx));
    t[1] = longint'($signed(w.ty));
    t[2] = longint'($signed(w.tz));
    g[0] = longint'($signed(w.sx));
    g[1] = longint'($signed(w.sy));
    g[2] = longint'($signed(w.sz));
    test = longint'($signed(w.test));
    phi  = longint'($signed(w.phi));
    i = w.position / 3;
    k = w.position % 3;
    a = (i + 1) % 3;
    b = (i + 2) % 3;
    c = (k + 1) % 3;
    d = (k + 2) % 3;
    sat_hit = 1'b0;
    sum = 0;
    s = 0;
    case (w.action)
      ACT_ELASTIC: begin
        for (int j = 0; j < 3; j++) begin
          inner = 0;
          for (int l = 0; l < 3; l++) inner += q_mul(c_at(i, j, k, l), g[l]);
          sum += q_mul(inner, t[j]);
        end
      end
      ACT_ELASTIC_ROT: begin
        for (int j = 0; j < 3; j++) begin
          s += q_mul(c_at(i, j, c, d), t[j]);
          s -= q_mul(c_at(i, j, d, c), t[j]);
        end
        sum = q_mul(s, phi);
      end
      ACT_MOMENT: begin
        for (int n = 0; n < 3; n++) begin
          s += q_mul(c_at(a, b, k, n), g[n]);
          s -= q_mul(c_at(b, a, k, n), g[n]);
        end
        sum = q_mul(test, s);
      end
      default: begin
        s = c_at(a, b, c, d) - c_at(a, b, d, c) - c_at(b, a, c, d) + c_at(b, a, d, c);
        sum = q_mul(q_mul(test, phi), s);
      end
    endcase
    sum = clip_q(sum);
    r.val = sum[31:0];
    r.ovf = sat_hit;
    return 1'b1;
  endfunction

  // Mostly small values so that results often stay in range
  function automatic logic [31:0] rand_q();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom();
      2: begin
        case ($urandom_range(0, 3))
          0: v = QMAX;
          1: v = QMIN;
          2: v = QZERO;
          default: v = QONE;
        endcase
      end
      3: v = 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
      default: v = 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
    endcase
    return v;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int unsigned pick;
    w.entry = rand_q();
    w.tx = rand_q();
    w.ty = rand_q();
    w.tz = rand_q();
    w.sx = rand_q();
    w.sy = rand_q();
    w.sz = rand_q();
    w.test = rand_q();
    w.phi = rand_q();
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      w.action = ACT_LOAD;
      w.position = POS_W'($urandom_range(0, STORE_DEPTH - 1));
    end else if (pick < 90) begin
      w.action = ACT_W'($urandom_range(ACT_ELASTIC, ACT_MOMENT_ROT));
      w.position = POS_W'($urandom_range(0, COMP_LAST));
    end else if (pick < 94) begin
      w.action = ACT_LOAD;
      w.position = POS_W'($urandom_range(STORE_DEPTH, POS_TOP));
    end else if (pick < 97) begin
      w.action = ACT_W'($urandom_range(ACT_ELASTIC, ACT_MOMENT_ROT));
      w.position = POS_W'($urandom_range(COMP_LAST + 1, POS_TOP));
    end else begin
      w.action = ACT_W'($urandom_range(ACT_SPARE5, ACT_SPARE7));
      w.position = POS_W'($urandom_range(0, POS_TOP));
    end
    return w;
  endfunction

  task automatic report_fault(string what);
    errors++;
    $display("%0t check failed: %s", $time, what);
  endtask

  // Offer one word, hold it until taken, then pace the next burst
  task automatic offer(word_t w, logic known, jac_t typed);
    jac_t r;
    int gap;
    in_valid        <= 1'b1;
    in_action       <= w.action;
    in_position     <= w.position;
    in_entry_value  <= w.entry;
    in_test_grad_x  <= w.tx;
    in_test_grad_y  <= w.ty;
    in_test_grad_z  <= w.tz;
    in_shape_grad_x <= w.sx;
    in_shape_grad_y <= w.sy;
    in_shape_grad_z <= w.sz;
    in_test_scalar  <= w.test;
    in_shape_scalar <= w.phi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_taken++;
    if (predict_jacobian(w, r)) begin
      jac_due.push_back(known ? typed : r);
      per_action[w.action]++;
    end else if (w.action == ACT_LOAD && w.position < STORE_DEPTH) begin
      loads++;
    end else begin
      dropped++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Sender: fill the tensor, walk the directed plan, then random words
  initial begin : sender
    word_t w;
    in_valid        <= 1'b0;
    in_action       <= '0;
    in_position     <= '0;
    in_entry_value  <= '0;
    in_test_grad_x  <= '0;
    in_test_grad_y  <= '0;
    in_test_grad_z  <= '0;
    in_shape_grad_x <= '0;
    in_shape_grad_y <= '0;
    in_shape_grad_z <= '0;
    in_test_scalar  <= '0;
    in_shape_scalar <= '0;
    rst_n           <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < STORE_DEPTH; p++) begin
      w = '0;
      w.action = ACT_LOAD;
      w.position = POS_W'(p);
      w.entry = QMAX;
      offer(w, 1'b0, '0);
    end
    foreach (plan[r]) offer(plan[r].w, plan[r].known, plan[r].res);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // pause until the block has drained every result
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (jac_due.size() != 0) @(posedge clk);
      end
      offer(rand_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then watch for stray results
    while (jac_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("sent %0d loads, %0d dropped words; elastic %0d, elastic-rot %0d, moment %0d,",
             loads, dropped, per_action[ACT_ELASTIC], per_action[ACT_ELASTIC_ROT],
             per_action[ACT_MOMENT]);
    $display("moment-rot %0d; %0d results checked, %0d saturated, one %0d-cycle output hold",
             per_action[ACT_MOMENT_ROT], results_seen, saturated, HOLD_CYCLES);
    if (errors == 0) begin
      $display("elasticity_jacobian_contraction: match");
    end else begin
      $display("elasticity_jacobian_contraction: mismatch");
    end
    $finish;
  end

  // Receiver: stall patterns of varying style, plus one long hold
  initial begin : receiver
    int style, len;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      style = $urandom_range(0, 3);
      len = $urandom_range(5, 60);
      repeat (len) begin
        if (!held && words_taken >= HOLD_AFTER) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (style)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ~out_ready;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Compare each result with the oldest pending entry
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_overflow) saturated++;
      if (jac_due.size() == 0) begin
        report_fault($sformatf("result %h with nothing pending", out_jacobian_value));
      end else begin
        head = jac_due.pop_front();
        if (out_jacobian_value !== head.val)
          report_fault($sformatf("jacobian_value %h, want %h", out_jacobian_value, head.val));
        if (out_overflow !== head.ovf)
          report_fault($sformatf("overflow %b, want %b", out_overflow, head.ovf));
      end
    end
  end

  // Stop when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", IDLE_LIMIT);
      $display("elasticity_jacobian_contraction: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

@@ elasticity_jacobian_contraction.f @@
hdl/ejc_pkg.sv
hdl/ejc_ram.sv
hdl/ejc_ctrl.sv
hdl/ejc_dp.sv
hdl/elasticity_jacobian_contraction.sv
test/tb.sv
